FILE: sv/multi_servo_linear_ramp_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-servo linear ramp core
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MULTI_SERVO_LINEAR_RAMP_CORE_ASSERT_SVH
`define MULTI_SERVO_LINEAR_RAMP_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSR_ASSERT_HOLDS(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/msr_pkg.sv
// ----------------------------------------------------------------------------
// Multi-servo linear ramp package
// Beat types, fixed constants and the microcode table of the ramp sequencer.
// ----------------------------------------------------------------------------
package msr_pkg;

  localparam int unsigned OUT_CHANNELS = 8;
  localparam int unsigned MAX_CHANNELS = 16;
  localparam int unsigned DUTY_W       = 12;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned TIME_W       = 16;
  localparam int unsigned RAMP_W       = 15;
  localparam int unsigned STEP_W       = 11;
  localparam int unsigned DIFF_W       = 12;
  localparam int unsigned PROD_W       = DIFF_W + STEP_W;
  localparam int unsigned SUM_W        = DUTY_W + 2;

  localparam logic [DUTY_W-1:0] PULSE_MIN  = 12'd500;
  localparam logic [DUTY_W-1:0] PULSE_MAX  = 12'd2500;
  localparam logic [DUTY_W-1:0] DUTY_RESET = 12'd1500;
  localparam logic [DUTY_W-1:0] DUTY_MAX   = 12'd4095;
  localparam logic [TIME_W-1:0] TIME_MIN   = 16'd20;
  localparam logic [TIME_W-1:0] TIME_MAX   = 16'd30000;
  localparam logic [RAMP_W-1:0] RAMP_RESET = 15'd2000;

  // Division by the 20 ms tick: drop two bits, then multiply by the
  // reciprocal of five. Exact for every 13-bit quarter value.
  localparam int unsigned    QTR_W       = RAMP_W - 2;
  localparam int unsigned    RECIP_W     = 16;
  localparam int unsigned    RECIP_SHIFT = 18;
  localparam int unsigned    RECIP_PW    = QTR_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 16'd52429;

  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic [STEP_W-1:0]        step_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic              operation;
    logic [CHAN_W-1:0] channel;
    duty_t             pulse;
    logic [TIME_W-1:0] move_time;
  } in_item_t;

  typedef struct packed {
    duty_t duty_ch0;
    duty_t duty_ch1;
    duty_t duty_ch2;
    duty_t duty_ch3;
    duty_t duty_ch4;
    duty_t duty_ch5;
    duty_t duty_ch6;
    duty_t duty_ch7;
    logic  moving;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

  // Microcode.
  localparam int unsigned UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  typedef enum logic [3:0] {
    A_NOP      = 4'd0,
    A_ACCEPT   = 4'd1,
    A_SET      = 4'd2,
    A_LATCH    = 4'd3,
    A_DEC      = 4'd4,
    A_FINISH   = 4'd5,
    A_DIV_LOAD = 4'd6,
    A_DIV_STEP = 4'd7,
    A_WRITE    = 4'd8,
    A_PRESENT  = 4'd9
  } uact_e;

  typedef enum logic [3:0] {
    C_NEVER       = 4'd0,
    C_ALWAYS      = 4'd1,
    C_NO_ACCEPT   = 4'd2,
    C_IS_TICK     = 4'd3,
    C_NO_PENDING  = 4'd4,
    C_NO_ACTIVE   = 4'd5,
    C_STEPS_NZ    = 4'd6,
    C_DIV_BUSY    = 4'd7,
    C_MORE_CH     = 4'd8,
    C_OUT_BLOCKED = 4'd9
  } ucond_e;

  typedef struct packed {
    uact_e  act;
    ucond_e cond;
    upc_t   target;
  } uword_t;

  localparam upc_t UPC_FETCH    = 4'd0;
  localparam upc_t UPC_DISPATCH = 4'd1;
  localparam upc_t UPC_SET      = 4'd2;
  localparam upc_t UPC_CHK_PEND = 4'd3;
  localparam upc_t UPC_LATCH    = 4'd4;
  localparam upc_t UPC_CHK_ACT  = 4'd5;
  localparam upc_t UPC_DEC      = 4'd6;
  localparam upc_t UPC_CHK_END  = 4'd7;
  localparam upc_t UPC_FINISH   = 4'd8;
  localparam upc_t UPC_DIV_LOAD = 4'd9;
  localparam upc_t UPC_DIV_STEP = 4'd10;
  localparam upc_t UPC_WRITE    = 4'd11;
  localparam upc_t UPC_OUT      = 4'd12;

  // A step jumps to its target when its condition holds, else falls through.
  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = '{act: A_NOP, cond: C_ALWAYS, target: UPC_FETCH};
    case (pc)
      UPC_FETCH:    w = '{act: A_ACCEPT,   cond: C_NO_ACCEPT,   target: UPC_FETCH};
      UPC_DISPATCH: w = '{act: A_NOP,      cond: C_IS_TICK,     target: UPC_CHK_PEND};
      UPC_SET:      w = '{act: A_SET,      cond: C_ALWAYS,      target: UPC_OUT};
      UPC_CHK_PEND: w = '{act: A_NOP,      cond: C_NO_PENDING,  target: UPC_CHK_ACT};
      UPC_LATCH:    w = '{act: A_LATCH,    cond: C_NEVER,       target: UPC_FETCH};
      UPC_CHK_ACT:  w = '{act: A_NOP,      cond: C_NO_ACTIVE,   target: UPC_OUT};
      UPC_DEC:      w = '{act: A_DEC,      cond: C_NEVER,       target: UPC_FETCH};
      UPC_CHK_END:  w = '{act: A_NOP,      cond: C_STEPS_NZ,    target: UPC_DIV_LOAD};
      UPC_FINISH:   w = '{act: A_FINISH,   cond: C_ALWAYS,      target: UPC_OUT};
      UPC_DIV_LOAD: w = '{act: A_DIV_LOAD, cond: C_NEVER,       target: UPC_FETCH};
      UPC_DIV_STEP: w = '{act: A_DIV_STEP, cond: C_DIV_BUSY,    target: UPC_DIV_STEP};
      UPC_WRITE:    w = '{act: A_WRITE,    cond: C_MORE_CH,     target: UPC_DIV_LOAD};
      UPC_OUT:      w = '{act: A_PRESENT,  cond: C_OUT_BLOCKED, target: UPC_OUT};
      default:      w = '{act: A_NOP,      cond: C_ALWAYS,      target: UPC_FETCH};
    endcase
    return w;
  endfunction

endpackage

FILE: sv/msr_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per step.
// ----------------------------------------------------------------------------
module msr_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 11
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  msr_pkg::div_ctl_t  ctl_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [DEN_W-1:0]   den_i,
  output logic [NUM_W-1:0]   quo_o,
  output logic               last_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_W - 1);

  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {rem_q, quo_q[NUM_W-1]};
    trial_sub = trial - {1'b0, den_i};
    fits      = (trial >= {1'b0, den_i});
    quo_d     = quo_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    if (ctl_i.load) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (ctl_i.step) begin
      quo_d = {quo_q[NUM_W-2:0], fits};
      rem_d = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign quo_o  = quo_q;
  assign last_o = (cnt_q == LAST_CNT);

endmodule

FILE: sv/multi_servo_linear_ramp_core.sv
// ----------------------------------------------------------------------------
// Multi-servo linear ramp core
// Servo pulse-width ramp generator run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake               | Beat
//   --------+-----------+-------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o | msr_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i | msr_pkg::out_item_t
//
// A set beat is accepted, checked and presented. A tick that advances a ramp
// runs the serial divider once per channel, one quotient bit per cycle for 23
// bits, and latches the new ramp first when it also starts one. The tick that
// ends a ramp puts every channel on its target, and an idle tick only presents
// the current duties.
// Reset puts every channel at 1500 us with no ramp running; no memory clear.
// A result waits in the output register while the next beat is taken in; the
// sequencer stalls only if a second result is ready before the first leaves.
//
module multi_servo_linear_ramp_core #(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  msr_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output msr_pkg::out_item_t  out_item_o
);

`include "multi_servo_linear_ramp_core_assert.svh"

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned CHC_W = msr_pkg::CHAN_W + 1;
  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CHC_W-1:0] NUM_CH  = CHC_W'(NUM_CHANNELS);

  // Sequencer state.
  msr_pkg::upc_t   pc_q, pc_d;
  msr_pkg::uword_t uw;
  logic            jump;

  // Ramp state. Every channel keeps its duty, target and the difference
  // latched when the ramp started.
  msr_pkg::duty_t  cur_q    [NUM_CHANNELS];
  msr_pkg::duty_t  cur_d    [NUM_CHANNELS];
  msr_pkg::duty_t  target_q [NUM_CHANNELS];
  msr_pkg::duty_t  target_d [NUM_CHANNELS];
  msr_pkg::diff_t  diff_q   [NUM_CHANNELS];
  msr_pkg::diff_t  diff_d   [NUM_CHANNELS];
  logic [msr_pkg::RAMP_W-1:0] ramp_time_q, ramp_time_d;
  logic            pending_q, pending_d;
  logic            active_q, active_d;
  msr_pkg::step_t  total_q, total_d;
  msr_pkg::step_t  steps_left_q, steps_left_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic            neg_q, neg_d;

  // Input beat and output register.
  msr_pkg::in_item_t  in_q;
  msr_pkg::out_item_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic               out_blocked;

  // Datapath signals.
  logic                          chan_ok;
  logic                          pulse_ok;
  logic [msr_pkg::TIME_W-1:0]    time_clamped;
  logic [msr_pkg::RECIP_PW-1:0]  recip_prod;
  msr_pkg::step_t                steps_calc;
  msr_pkg::diff_t                diff_sel;
  logic [msr_pkg::DIFF_W-1:0]    diff_mag;
  logic [msr_pkg::PROD_W-1:0]    div_num;
  logic [msr_pkg::PROD_W-1:0]    div_quo;
  logic                          div_last;
  msr_pkg::div_ctl_t             div_ctl;
  logic [msr_pkg::DIFF_W-1:0]    q_mag;
  logic signed [msr_pkg::SUM_W-1:0] q_signed;
  logic signed [msr_pkg::SUM_W-1:0] duty_sum;
  msr_pkg::duty_t                duty_sat;
  msr_pkg::duty_t                dut [msr_pkg::MAX_CHANNELS];

  // The control word for the current step comes straight from the table.
  assign uw         = msr_pkg::ucode_rom(pc_q);
  assign in_ready_o = (uw.act == msr_pkg::A_ACCEPT);
  assign out_blocked = out_valid_q && !out_ready_i;

  // Branch conditions.
  always_comb begin
    case (uw.cond)
      msr_pkg::C_NEVER:       jump = 1'b0;
      msr_pkg::C_ALWAYS:      jump = 1'b1;
      msr_pkg::C_NO_ACCEPT:   jump = !in_valid_i;
      msr_pkg::C_IS_TICK:     jump = (in_q.operation == msr_pkg::OP_TICK);
      msr_pkg::C_NO_PENDING:  jump = !pending_q;
      msr_pkg::C_NO_ACTIVE:   jump = !active_q;
      msr_pkg::C_STEPS_NZ:    jump = (steps_left_q != '0);
      msr_pkg::C_DIV_BUSY:    jump = !div_last;
      msr_pkg::C_MORE_CH:     jump = (ch_q != LAST_CH);
      msr_pkg::C_OUT_BLOCKED: jump = out_blocked;
      default:                jump = 1'b0;
    endcase
    pc_d = jump ? uw.target : pc_q + 1'b1;
  end

  // A set is valid only for an existing channel and an in-range pulse; the
  // move time is clamped into the legal window.
  always_comb begin
    chan_ok  = ({1'b0, in_q.channel} < NUM_CH);
    pulse_ok = (in_q.pulse >= msr_pkg::PULSE_MIN) && (in_q.pulse <= msr_pkg::PULSE_MAX);
    if (in_q.move_time < msr_pkg::TIME_MIN) begin
      time_clamped = msr_pkg::TIME_MIN;
    end else if (in_q.move_time > msr_pkg::TIME_MAX) begin
      time_clamped = msr_pkg::TIME_MAX;
    end else begin
      time_clamped = in_q.move_time;
    end
  end

  // Step count is the ramp time over the 20 ms tick period. The time is first
  // divided by four with a shift, then by five through the reciprocal.
  assign recip_prod = msr_pkg::RECIP_PW'(ramp_time_q[msr_pkg::RAMP_W-1:2])
                    * msr_pkg::RECIP_PW'(msr_pkg::RECIP_FIVE);
  assign steps_calc = recip_prod[msr_pkg::RECIP_SHIFT +: msr_pkg::STEP_W];

  // The divider sees the magnitude of difference times remaining steps; the
  // sign is kept aside so the quotient truncates toward zero.
  assign diff_sel = diff_q[ch_q];
  assign diff_mag = diff_sel[msr_pkg::DIFF_W-1] ? msr_pkg::DIFF_W'(-diff_sel)
                                                : msr_pkg::DIFF_W'(diff_sel);
  assign div_num  = msr_pkg::PROD_W'(diff_mag) * msr_pkg::PROD_W'(steps_left_q);
  assign div_ctl  = '{load: (uw.act == msr_pkg::A_DIV_LOAD),
                      step: (uw.act == msr_pkg::A_DIV_STEP)};

  msr_div #(
    .NUM_W (msr_pkg::PROD_W),
    .DEN_W (msr_pkg::STEP_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (div_num),
    .den_i  (total_q),
    .quo_o  (div_quo),
    .last_o (div_last)
  );

  // New duty for the channel in hand: target plus the signed, scaled
  // difference, saturated to the 12-bit range. A zero step count, which
  // cannot happen after a valid set, contributes nothing.
  always_comb begin
    q_mag    = (total_q == '0) ? '0 : div_quo[msr_pkg::DIFF_W-1:0];
    q_signed = neg_q ? -msr_pkg::SUM_W'(q_mag) : msr_pkg::SUM_W'(q_mag);
    duty_sum = $signed(msr_pkg::SUM_W'(target_q[ch_q])) + q_signed;
    if (duty_sum < 0) begin
      duty_sat = '0;
    end else if (duty_sum > $signed(msr_pkg::SUM_W'(msr_pkg::DUTY_MAX))) begin
      duty_sat = msr_pkg::DUTY_MAX;
    end else begin
      duty_sat = duty_sum[msr_pkg::DUTY_W-1:0];
    end
  end

  // Channels that do not exist report zero.
  always_comb begin
    for (int k = 0; k < msr_pkg::MAX_CHANNELS; k++) begin
      dut[k] = '0;
    end
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      dut[i] = cur_q[i];
    end
  end

  // Actions of the control word.
  always_comb begin
    cur_d        = cur_q;
    target_d     = target_q;
    diff_d       = diff_q;
    ramp_time_d  = ramp_time_q;
    pending_d    = pending_q;
    active_d     = active_q;
    total_d      = total_q;
    steps_left_d = steps_left_q;
    ch_d         = ch_q;
    neg_d        = neg_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    case (uw.act)
      msr_pkg::A_SET: begin
        if (chan_ok && pulse_ok) begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (in_q.channel == msr_pkg::CHAN_W'(i)) begin
              target_d[i] = in_q.pulse;
            end
          end
          ramp_time_d = time_clamped[msr_pkg::RAMP_W-1:0];
          pending_d   = 1'b1;
        end
      end
      msr_pkg::A_LATCH: begin
        // Start a fresh ramp from wherever the channels are now.
        pending_d    = 1'b0;
        active_d     = 1'b1;
        total_d      = steps_calc;
        steps_left_d = steps_calc;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          diff_d[i] = msr_pkg::diff_t'(cur_q[i] - target_q[i]);
        end
      end
      msr_pkg::A_DEC: begin
        steps_left_d = steps_left_q - 1'b1;
        ch_d         = '0;
      end
      msr_pkg::A_FINISH: begin
        // Last step of a ramp: every channel lands on its target.
        cur_d    = target_q;
        active_d = 1'b0;
      end
      msr_pkg::A_DIV_LOAD: begin
        neg_d = diff_sel[msr_pkg::DIFF_W-1];
      end
      msr_pkg::A_WRITE: begin
        cur_d[ch_q] = duty_sat;
        if (ch_q != LAST_CH) begin
          ch_d = ch_q + 1'b1;
        end
      end
      msr_pkg::A_PRESENT: begin
        if (!out_blocked) begin
          out_d.duty_ch0 = dut[0];
          out_d.duty_ch1 = dut[1];
          out_d.duty_ch2 = dut[2];
          out_d.duty_ch3 = dut[3];
          out_d.duty_ch4 = dut[4];
          out_d.duty_ch5 = dut[5];
          out_d.duty_ch6 = dut[6];
          out_d.duty_ch7 = dut[7];
          out_d.moving   = active_q;
          out_valid_d    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= msr_pkg::UPC_FETCH;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        cur_q[i]    <= msr_pkg::DUTY_RESET;
        target_q[i] <= msr_pkg::DUTY_RESET;
        diff_q[i]   <= '0;
      end
      ramp_time_q  <= msr_pkg::RAMP_RESET;
      pending_q    <= 1'b0;
      active_q     <= 1'b0;
      total_q      <= '0;
      steps_left_q <= '0;
      ch_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pc_q         <= pc_d;
      cur_q        <= cur_d;
      target_q     <= target_d;
      diff_q       <= diff_d;
      ramp_time_q  <= ramp_time_d;
      pending_q    <= pending_d;
      active_q     <= active_d;
      total_q      <= total_d;
      steps_left_q <= steps_left_d;
      ch_q         <= ch_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    neg_q <= neg_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Between beats a running ramp always has steps left, and fewer than it
  // started with.
  `MSR_ASSERT_HOLDS(a_ramp_steps_in_range, clk_i, rst_ni,
    (pc_q == msr_pkg::UPC_FETCH) && active_q,
    (steps_left_q != '0) && (steps_left_q < total_q), "ramp step count out of range")

  // The divider never runs against a zero step count.
  `MSR_ASSERT_HOLDS(a_div_nonzero, clk_i, rst_ni,
    pc_q == msr_pkg::UPC_DIV_STEP, total_q != '0, "division by zero step count")

  // The scaled difference always fits in the width of the difference itself.
  `MSR_ASSERT_HOLDS(a_quotient_fits, clk_i, rst_ni,
    pc_q == msr_pkg::UPC_WRITE, div_quo[msr_pkg::PROD_W-1:msr_pkg::DIFF_W] == '0,
    "ramp quotient overflow")

  // A presented result shows up on the port with the ramp flag of that moment.
  `MSR_ASSERT_NEXT(a_present_lands, clk_i, rst_ni,
    (uw.act == msr_pkg::A_PRESENT) && !out_blocked,
    out_valid_o && (out_item_o.moving == $past(active_q)), "result beat not presented")

endmodule
